/* rtl/periodic_pump_interval_scheduler_macros.svh */
// Assertion macros shared by the scheduler RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef PERIODIC_PUMP_INTERVAL_SCHEDULER_MACROS_SVH
`define PERIODIC_PUMP_INTERVAL_SCHEDULER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PISC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication.
`define PISC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`else

`define PISC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PISC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/pisc_pkg.sv */
package pisc_pkg;

   localparam int NOW_W      = 32;
   localparam int FIELD_W    = 16;
   localparam int DAILY_W    = 24;
   localparam int WAKE_W     = 15;
   localparam int CAND_W     = 22;
   localparam int PUMP_IDX_W = 2;
   localparam int SLOT_COUNT = 4;
   localparam int TABLE_W    = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CAND_W-1:0] SECONDS_PER_MINUTE = CAND_W'(60);
   localparam logic [CAND_W-1:0] FIRST_RUN_DELAY    = CAND_W'(5 * 60);
   localparam logic [CAND_W-1:0] MIN_DELAY          = CAND_W'(60);
   localparam logic [CAND_W-1:0] MAX_DELAY          = CAND_W'(6 * 3600);
   localparam logic [CAND_W-1:0] FALLBACK_DELAY     = CAND_W'(3600);
   localparam logic [CAND_W-1:0] BEST_INIT          = {CAND_W{1'b1}};
   localparam logic [DAILY_W-1:0] DAILY_MAX         = {DAILY_W{1'b1}};

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE_MASK    = 2'd0,
      CSR_INTERVAL_TABLE = 2'd1,
      CSR_RUN_TABLE      = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAKE,
      ST_DONE
   } state_type;

   // Verdict of the shared slot evaluator for one pump.
   typedef struct packed {
      logic              due;
      logic [CAND_W-1:0] cand;
   } slot_eval_type;

endpackage

/* rtl/pisc_chan_if.sv */
interface pisc_req_if;
   logic                        valid;
   logic                        ready;
   logic [pisc_pkg::NOW_W-1:0]  now_seconds;
   logic                        day_reset;

   modport source (output valid, output now_seconds, output day_reset, input ready);
   modport sink   (input valid, input now_seconds, input day_reset, output ready);
endinterface

interface pisc_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            fired;
   logic [pisc_pkg::PUMP_IDX_W-1:0] fired_pump;
   logic [pisc_pkg::FIELD_W-1:0]    run_duration;
   logic [pisc_pkg::DAILY_W-1:0]    daily_total;
   logic [pisc_pkg::WAKE_W-1:0]     wake_delay;

   modport source (output valid, output fired, output fired_pump, output run_duration,
                   output daily_total, output wake_delay, input ready);
   modport sink   (input valid, input fired, input fired_pump, input run_duration,
                   input daily_total, input wake_delay, output ready);
endinterface

/* rtl/pisc_slot_eval.sv */
module pisc_slot_eval (
   input  logic [pisc_pkg::NOW_W-1:0]   now_seconds,
   input  logic [pisc_pkg::NOW_W-1:0]   last_run,
   input  logic [pisc_pkg::FIELD_W-1:0] interval,
   output pisc_pkg::slot_eval_type      result
);

   logic                           never_run;
   logic [pisc_pkg::CAND_W-1:0]    need;
   logic [pisc_pkg::NOW_W-1:0]     elapsed;
   logic                           elapsed_ok;

   always_comb begin
      never_run  = (last_run == '0);
      need       = pisc_pkg::CAND_W'(interval) * pisc_pkg::SECONDS_PER_MINUTE;
      // wraps modulo 2^32, so a clock that stepped back reads as overdue
      elapsed    = now_seconds - last_run;
      elapsed_ok = (elapsed >= pisc_pkg::NOW_W'(need));
      result.due = never_run || elapsed_ok;
      if (never_run) begin
         result.cand = pisc_pkg::FIRST_RUN_DELAY;
      end else if (elapsed_ok) begin
         result.cand = '0;
      end else begin
         result.cand = need - elapsed[pisc_pkg::CAND_W-1:0];
      end
   end

endmodule

/* rtl/periodic_pump_interval_scheduler.sv */
// Periodic pump interval scheduler.
// req_chan carries one wake transfer: the epoch second and a day-reset flag.
// rsp_chan returns exactly one transfer per wake: whether a pump fired, its
// index, run minutes and accumulated daily minutes, and the seconds until
// the next wake (60..21600). csr_* writes enable_mask (0), interval_table (1)
// and run_table (2); write only while no wake is in flight.
// Sequence: after a wake is taken the sequencer scans one pump a cycle up to
// the first due pump or the last pump (no scan for a day-reset wake), then makes
// a pass over all pumps for the wake-delay minimum and loads the output
// register. The next wake is taken only once the sequencer is idle again.
// Both passes share a single slot evaluator (one 32-bit subtract, compare and
// 22-bit subtract) that a small sequencer steps across the pumps.
// req_chan.ready is high only while the sequencer idles, so a new wake is
// taken while the previous result still waits in the output register.
// If the receiver stalls, the sequencer holds its finished result until the
// output register frees up. Synchronous reset clears the sequencer, the
// configuration, every last-run time and daily total, and the output valid flag.
`include "periodic_pump_interval_scheduler_macros.svh"

module periodic_pump_interval_scheduler #(
   parameter int NUM_PUMPS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   pisc_req_if.sink                              req_chan,
   pisc_rsp_if.source                            rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [pisc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pisc_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int IDX_W = (NUM_PUMPS > 1) ? $clog2(NUM_PUMPS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PUMPS - 1);

   // configuration
   logic [pisc_pkg::SLOT_COUNT-1:0] enable_ff;
   logic [pisc_pkg::TABLE_W-1:0]    interval_ff;
   logic [pisc_pkg::TABLE_W-1:0]    run_ff;

   // per-pump state
   logic [pisc_pkg::NOW_W-1:0]   last_run_ff [NUM_PUMPS];
   logic [pisc_pkg::DAILY_W-1:0] daily_ff    [NUM_PUMPS];

   // sequencer
   pisc_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;

   // working registers of the wake in flight
   logic [pisc_pkg::NOW_W-1:0]      now_ff;
   logic                            fired_ff;
   logic [pisc_pkg::PUMP_IDX_W-1:0] pump_ff;
   logic [pisc_pkg::FIELD_W-1:0]    dur_ff;
   logic [pisc_pkg::DAILY_W-1:0]    total_ff;
   logic [pisc_pkg::CAND_W-1:0]     best_ff;

   // output register
   logic                            rsp_valid_ff;
   logic                            rsp_fired_ff;
   logic [pisc_pkg::PUMP_IDX_W-1:0] rsp_pump_ff;
   logic [pisc_pkg::FIELD_W-1:0]    rsp_dur_ff;
   logic [pisc_pkg::DAILY_W-1:0]    rsp_total_ff;
   logic [pisc_pkg::WAKE_W-1:0]     rsp_wake_ff;

   // combinational
   logic [pisc_pkg::PUMP_IDX_W-1:0] slot;
   logic [pisc_pkg::FIELD_W-1:0]    slot_interval;
   logic [pisc_pkg::FIELD_W-1:0]    slot_run;
   logic                            slot_on;
   logic                            last_slot;
   pisc_pkg::slot_eval_type         slot_eval;
   logic [pisc_pkg::DAILY_W:0]      daily_sum;
   logic [pisc_pkg::DAILY_W-1:0]    daily_sat;
   logic [pisc_pkg::WAKE_W-1:0]     wake_clamped;
   logic                            req_accept;
   logic                            fire_now;
   logic                            rsp_load;
   logic                            ready;

   assign slot          = pisc_pkg::PUMP_IDX_W'(idx_ff);
   assign slot_interval = interval_ff[{slot, 4'b0000} +: pisc_pkg::FIELD_W];
   assign slot_run      = run_ff[{slot, 4'b0000} +: pisc_pkg::FIELD_W];
   assign slot_on       = enable_ff[slot];
   assign last_slot     = (idx_ff == LAST_IDX);

   // the one arithmetic unit, shared by the scan and the wake-delay pass
   pisc_slot_eval u_slot_eval (
      .now_seconds (now_ff),
      .last_run    (last_run_ff[idx_ff]),
      .interval    (slot_interval),
      .result      (slot_eval)
   );

   // saturate the daily total
   always_comb begin
      daily_sum = {1'b0, daily_ff[idx_ff]} + (pisc_pkg::DAILY_W + 1)'(slot_run);
      daily_sat = daily_sum[pisc_pkg::DAILY_W] ? pisc_pkg::DAILY_MAX
                                               : daily_sum[pisc_pkg::DAILY_W-1:0];
   end

   // clamp the minimum; no enabled pump leaves BEST_INIT and lands on the fallback
   always_comb begin
      if (best_ff < pisc_pkg::MIN_DELAY) begin
         wake_clamped = pisc_pkg::WAKE_W'(pisc_pkg::MIN_DELAY);
      end else if (best_ff > pisc_pkg::MAX_DELAY) begin
         wake_clamped = pisc_pkg::WAKE_W'(pisc_pkg::FALLBACK_DELAY);
      end else begin
         wake_clamped = best_ff[pisc_pkg::WAKE_W-1:0];
      end
   end

   assign rsp_load   = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && ready;

   // next state and strobes
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      ready    = 1'b0;
      fire_now = 1'b0;
      unique case (state_ff)
         pisc_pkg::ST_IDLE: begin
            ready  = 1'b1;
            idx_in = '0;
            if (req_chan.valid) begin
               state_in = req_chan.day_reset ? pisc_pkg::ST_WAKE : pisc_pkg::ST_SCAN;
            end
         end
         pisc_pkg::ST_SCAN: begin
            fire_now = slot_on && slot_eval.due;
            if (fire_now || last_slot) begin
               state_in = pisc_pkg::ST_WAKE;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pisc_pkg::ST_WAKE: begin
            if (last_slot) begin
               state_in = pisc_pkg::ST_DONE;
               idx_in   = '0;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pisc_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = pisc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pisc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pisc_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         interval_ff  <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_PUMPS; i++) begin
            last_run_ff[i] <= '0;
            daily_ff[i]    <= '0;
         end
      end else begin
         // register writes; an unknown index is dropped
         if (csr_write_enable) begin
            unique case (csr_index)
               pisc_pkg::CSR_ENABLE_MASK:
                  enable_ff <= csr_write_data[pisc_pkg::SLOT_COUNT-1:0];
               pisc_pkg::CSR_INTERVAL_TABLE:
                  interval_ff <= csr_write_data;
               pisc_pkg::CSR_RUN_TABLE:
                  run_ff <= csr_write_data;
               default: begin
               end
            endcase
         end

         // take the wake and start a fresh result
         if (req_accept) begin
            now_ff   <= req_chan.now_seconds;
            fired_ff <= 1'b0;
            pump_ff  <= '0;
            dur_ff   <= '0;
            total_ff <= '0;
            best_ff  <= pisc_pkg::BEST_INIT;
            if (req_chan.day_reset) begin
               for (int i = 0; i < NUM_PUMPS; i++) begin
                  last_run_ff[i] <= '0;
                  daily_ff[i]    <= '0;
               end
            end
         end

         // first due pump fires; its new last-run time feeds the wake pass
         if (fire_now) begin
            last_run_ff[idx_ff] <= now_ff;
            daily_ff[idx_ff]    <= daily_sat;
            fired_ff            <= 1'b1;
            pump_ff             <= slot;
            dur_ff              <= slot_run;
            total_ff            <= daily_sat;
         end

         // advance the running minimum over enabled pumps
         if (state_ff == pisc_pkg::ST_WAKE && slot_on && slot_eval.cand < best_ff) begin
            best_ff <= slot_eval.cand;
         end

         // hand over to the output register, or drop it once transferred
         if (state_ff == pisc_pkg::ST_DONE && rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_fired_ff <= fired_ff;
            rsp_pump_ff  <= pump_ff;
            rsp_dur_ff   <= dur_ff;
            rsp_total_ff <= total_ff;
            rsp_wake_ff  <= wake_clamped;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_chan.ready        = ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.fired        = rsp_fired_ff;
   assign rsp_chan.fired_pump   = rsp_pump_ff;
   assign rsp_chan.run_duration = rsp_dur_ff;
   assign rsp_chan.daily_total  = rsp_total_ff;
   assign rsp_chan.wake_delay   = rsp_wake_ff;

   `PISC_ASSERT_NOW(a_wake_in_range, clock, reset, rsp_valid_ff,
      rsp_wake_ff >= pisc_pkg::WAKE_W'(pisc_pkg::MIN_DELAY) &&
      rsp_wake_ff <= pisc_pkg::WAKE_W'(pisc_pkg::MAX_DELAY))
   `PISC_ASSERT_NOW(a_quiet_when_unfired, clock, reset, rsp_valid_ff && !rsp_fired_ff,
      rsp_pump_ff == '0 && rsp_dur_ff == '0 && rsp_total_ff == '0)
   `PISC_ASSERT_NEXT(a_best_never_rises, clock, reset, state_ff == pisc_pkg::ST_WAKE,
      best_ff <= $past(best_ff))
   `PISC_ASSERT_NEXT(a_day_reset_clears, clock, reset,
      req_accept && req_chan.day_reset,
      last_run_ff[0] == '0 && daily_ff[0] == '0 && !fired_ff)
   `PISC_ASSERT_NOW(a_fire_only_enabled, clock, reset, fire_now,
      enable_ff[slot] && state_ff == pisc_pkg::ST_SCAN)

endmodule
